// ===== hdl/qwa_pkg.sv =====
package qwa_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int WWIN         = 10;
   localparam int SUM_W        = 34;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REF_RD,
      ST_REF_LD,
      ST_ENT_RD,
      ST_ENT_LD,
      ST_DOT,
      ST_FLIP,
      ST_ACC,
      ST_SQR,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_NEXT,
      ST_OUT
   } state_type;

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Q0.16 weights, oldest to newest
   function automatic logic [15:0] weight(input logic [3:0] idx);
      logic [15:0] w;
      case (idx)
         4'd0:    w = 16'd655;
         4'd1:    w = 16'd1311;
         4'd2:    w = 16'd2621;
         4'd3:    w = 16'd3277;
         4'd4:    w = 16'd5243;
         4'd5:    w = 16'd7209;
         4'd6:    w = 16'd9830;
         4'd7:    w = 16'd11141;
         4'd8:    w = 16'd11796;
         4'd9:    w = 16'd12452;
         default: w = 16'd0;
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/quaternion_window_averager.sv =====
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata: q_w,q_x,q_y,q_z; tuser: cmd
// rsp      out  rsp_tvalid/rsp_tready  tdata: mean w..z, wmean w..z; tuser: valids
// A push walks every stored entry (and, in the weighted pass, the window) through one shared
// 33x33 multiplier, then per average 4 squares, a 32-step square root and four 18-step
// divisions; a clear goes straight to the result.
// Reset (synchronous) empties the ring; the sample memory itself is not cleared.
// req_tready is high only in idle; a result holds until rsp_tready.
module quaternion_window_averager #(
   parameter int CAPACITY = qwa_pkg::CAPACITY_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // q_w, q_x, q_y, q_z
   input  logic [0:0]   req_tuser,   // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // mean_w..mean_z, wmean_w..wmean_z
   output logic [1:0]   rsp_tuser    // mean_valid, wmean_valid
);
   import qwa_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FW = $clog2(CAPACITY + 1);
   localparam logic [AW:0] CAP_X  = (AW+1)'(CAPACITY);
   localparam logic [AW:0] WWIN_X = (AW+1)'(WWIN);

   state_type state_ff, state_in;
   logic pass_ff, pass_in;
   logic [AW-1:0] wp_ff, wp_in, op_ff, op_in, ea_ff, ea_in;
   logic [FW-1:0] fill_ff, fill_in, idx_ff, idx_in;
   logic [1:0] k_ff, k_in;
   logic signed [15:0] ref_ff [4], ref_in [4];
   logic signed [16:0] cur_ff [4], cur_in [4];
   logic signed [34:0] dot_ff, dot_in;
   logic signed [SUM_W-1:0] s_ff [4], s_in [4];
   logic [63:0] n2_ff, n2_in, x_ff, x_in, root_ff, root_in, bit_ff, bit_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [50:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [17:0] quo_ff, quo_in;
   logic [15:0] mean_ff [4], mean_in [4], wm_ff [4], wm_in [4];
   logic mv_ff, mv_in, wv_ff, wv_in;

   logic [63:0] mem [CAPACITY];
   logic [63:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic we;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic [31:0] mag_k;
   logic [64:0] sq_sum;
   logic [51:0] trial;
   logic [17:0] quo_nx;
   logic [15:0] sat_v;
   logic [AW-1:0] wp_inc, op_inc, ea_inc, newest, base;
   logic [AW:0] wp_x;

   function automatic logic [31:0] mag32(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] a;
      a = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
      return a[31:0];
   endfunction

   assign prod   = mul_a * mul_b;
   assign mag_k  = mag32(s_ff[k_ff]);
   assign wp_inc = (wp_ff == AW'(CAPACITY - 1)) ? '0 : wp_ff + 1'b1;
   assign op_inc = (op_ff == AW'(CAPACITY - 1)) ? '0 : op_ff + 1'b1;
   assign ea_inc = (ea_ff == AW'(CAPACITY - 1)) ? '0 : ea_ff + 1'b1;
   assign wp_x   = {1'b0, wp_ff};
   assign newest = (wp_ff == '0) ? AW'(CAPACITY - 1) : wp_ff - 1'b1;
   assign base   = (wp_x >= WWIN_X) ? AW'(wp_x - WWIN_X) : AW'(wp_x + CAP_X - WWIN_X);
   assign sq_sum = {1'b0, root_ff} + {1'b0, bit_ff};
   assign trial  = {1'b0, rem_ff} - {1'b0, dsh_ff};
   assign quo_nx = {quo_ff[16:0], ~trial[51]};

   always_comb begin
      if (s_ff[k_ff] < 0) begin
         sat_v = (quo_nx >= 18'd32768) ? 16'h8000 : 16'(~quo_nx[15:0] + 16'd1);
      end else begin
         sat_v = (quo_nx >= 18'd32767) ? 16'h7fff : quo_nx[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wp_ff] <= req_tdata;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= '0;
         op_ff    <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         op_ff    <= op_in;
         fill_ff  <= fill_in;
      end
      pass_ff <= pass_in;
      ea_ff   <= ea_in;
      idx_ff  <= idx_in;
      k_ff    <= k_in;
      dot_ff  <= dot_in;
      n2_ff   <= n2_in;
      x_ff    <= x_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      mv_ff   <= mv_in;
      wv_ff   <= wv_in;
      ref_ff  <= ref_in;
      cur_ff  <= cur_in;
      s_ff    <= s_in;
      mean_ff <= mean_in;
      wm_ff   <= wm_in;
   end

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      wp_in    = wp_ff;
      op_in    = op_ff;
      fill_in  = fill_ff;
      ea_in    = ea_ff;
      idx_in   = idx_ff;
      k_in     = k_ff;
      dot_in   = dot_ff;
      n2_in    = n2_ff;
      x_in     = x_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      mv_in    = mv_ff;
      wv_in    = wv_ff;
      ref_in   = ref_ff;
      cur_in   = cur_ff;
      s_in     = s_ff;
      mean_in  = mean_ff;
      wm_in    = wm_ff;
      we       = 1'b0;
      rd_addr  = ea_ff;
      mul_a    = 33'(cur_ff[k_ff]);
      mul_b    = 33'(ref_ff[k_ff]);
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               for (int i = 0; i < 4; i++) begin
                  mean_in[i] = '0;
                  wm_in[i]   = '0;
               end
               if (req_tuser[0] == CMD_CLEAR) begin
                  wp_in   = '0;
                  op_in   = '0;
                  fill_in = '0;
                  mv_in   = 1'b0;
                  wv_in   = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  we    = 1'b1;
                  wp_in = wp_inc;
                  if (fill_ff < FW'(CAPACITY)) begin
                     fill_in = fill_ff + 1'b1;
                  end else begin
                     op_in = op_inc;
                  end
                  mv_in   = 1'b1;
                  wv_in   = (fill_in >= FW'(WWIN));
                  pass_in = 1'b0;
                  state_in = ST_REF_RD;
               end
            end
         end
         ST_REF_RD: begin
            rd_addr  = pass_ff ? newest : op_ff;
            state_in = ST_REF_LD;
         end
         ST_REF_LD: begin
            for (int i = 0; i < 4; i++) begin
               ref_in[i] = rd_ff[16*i +: 16];
               s_in[i]   = '0;
            end
            ea_in    = pass_ff ? base : op_ff;
            idx_in   = '0;
            state_in = ST_ENT_RD;
         end
         ST_ENT_RD: begin
            state_in = ST_ENT_LD;
         end
         ST_ENT_LD: begin
            for (int i = 0; i < 4; i++) begin
               cur_in[i] = 17'($signed(rd_ff[16*i +: 16]));
            end
            k_in     = '0;
            dot_in   = '0;
            state_in = ST_DOT;
         end
         ST_DOT: begin
            dot_in = dot_ff + prod[34:0];
            k_in   = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               state_in = ST_FLIP;
            end
         end
         ST_FLIP: begin
            // align to reference: -(-32768) fits in 17 bits
            for (int i = 0; i < 4; i++) begin
               cur_in[i] = dot_ff[34] ? -cur_ff[i] : cur_ff[i];
               if (!pass_ff) begin
                  s_in[i] = s_ff[i] + SUM_W'(cur_in[i]);
               end
            end
            k_in = '0;
            if (pass_ff) begin
               state_in = ST_ACC;
            end else begin
               state_in = ST_NEXT;
               idx_in   = idx_ff + 1'b1;
               ea_in    = ea_inc;
               state_in = (idx_ff == fill_ff - 1'b1) ? ST_SQR : ST_ENT_RD;
               n2_in    = '0;
            end
         end
         ST_ACC: begin
            mul_b        = 33'({1'b0, weight(idx_ff[3:0])});
            s_in[k_ff]   = s_ff[k_ff] + prod[SUM_W-1:0];
            k_in         = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               idx_in   = idx_ff + 1'b1;
               ea_in    = ea_inc;
               state_in = (idx_ff == FW'(WWIN - 1)) ? ST_SQR : ST_ENT_RD;
               n2_in    = '0;
            end
         end
         ST_SQR: begin
            mul_a = {1'b0, mag_k};
            mul_b = {1'b0, mag_k};
            n2_in = n2_ff + prod[63:0];
            k_in  = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               x_in     = n2_in;
               root_in  = '0;
               bit_in   = 64'd1 << 62;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if ({1'b0, x_ff} >= sq_sum) begin
               x_in    = x_ff - sq_sum[63:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               k_in = '0;
               if (n2_ff == '0) begin
                  // all sums zero: reference sample as is
                  for (int i = 0; i < 4; i++) begin
                     if (pass_ff) wm_in[i] = ref_ff[i];
                     else         mean_in[i] = ref_ff[i];
                  end
                  state_in = ST_NEXT;
               end else begin
                  state_in = ST_DIV_INIT;
               end
            end
         end
         ST_DIV_INIT: begin
            rem_in   = {3'b0, mag_k, 16'b0} + {19'b0, root_ff[31:0]};
            dsh_in   = {root_ff[32:0], 18'b0};
            quo_in   = '0;
            cnt_in   = 5'd17;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!trial[51]) begin
               rem_in = trial[50:0];
            end
            quo_in = quo_nx;
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (pass_ff) wm_in[k_ff] = sat_v;
               else         mean_in[k_ff] = sat_v;
               k_in     = k_ff + 1'b1;
               state_in = (k_ff == 2'd3) ? ST_NEXT : ST_DIV_INIT;
            end
         end
         ST_NEXT: begin
            if (!pass_ff && wv_ff) begin
               pass_in  = 1'b1;
               state_in = ST_REF_RD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tdata = {wm_ff[3], wm_ff[2], wm_ff[1], wm_ff[0],
                       mean_ff[3], mean_ff[2], mean_ff[1], mean_ff[0]};
   assign rsp_tuser = {wv_ff, mv_ff};

endmodule

// ===== test/tb_quaternion_window_averager.sv =====
module tb_quaternion_window_averager;
   timeunit 1ns;
   timeprecision 1ps;
   import qwa_pkg::*;

   localparam int RING = CAPACITY_DEF;

   typedef struct {
      logic [1:0]  valid;
      logic [15:0] comp [8];
   } avg_result_type;

   class qwa_scoreboard;
      logic signed [15:0] ring [RING][4];
      int unsigned        wr_ptr, old_ptr, fill;
      avg_result_type     pending [$];
      int                 errors;

      function new();
         wr_ptr = 0; old_ptr = 0; fill = 0; errors = 0;
      endfunction

      function bit [63:0] root(bit [63:0] x);
         bit [63:0] res, b;
         res = 0;
         b = 64'd1 << 62;
         for (int k = 0; k < 32; k++) begin
            if (x >= res + b) begin
               x = x - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function longint dot(int unsigned a, int unsigned b);
         longint d;
         d = 0;
         for (int k = 0; k < 4; k++) d += longint'(ring[a][k]) * longint'(ring[b][k]);
         return d;
      endfunction

      // scale to unit length; zero sum falls back to the reference entry
      function void unit_scale(longint s [4], int unsigned ref_idx, int base,
                               ref avg_result_type r);
         bit [63:0] mag [4];
         bit [63:0] n2, rt, q;
         n2 = 0;
         for (int k = 0; k < 4; k++) begin
            mag[k] = (s[k] < 0) ? -s[k] : s[k];
            n2 += mag[k] * mag[k];
         end
         if (n2 == 0) begin
            for (int k = 0; k < 4; k++) r.comp[base + k] = ring[ref_idx][k];
            return;
         end
         rt = root(n2);
         for (int k = 0; k < 4; k++) begin
            q = (mag[k] * 64'd65536 + rt) / (2 * rt);
            if (s[k] < 0) r.comp[base + k] = (q >= 32768) ? 16'h8000 : 16'(-q);
            else          r.comp[base + k] = (q >= 32767) ? 16'h7fff : 16'(q);
         end
      endfunction

      function void note_request(logic cmd, logic [63:0] data);
         avg_result_type r;
         longint s [4];
         int unsigned idx, base, newest;
         longint c;
         r.valid = 2'b00;
         for (int k = 0; k < 8; k++) r.comp[k] = 0;
         if (cmd == CMD_CLEAR) begin
            wr_ptr = 0; old_ptr = 0; fill = 0;
            pending.push_back(r);
            return;
         end
         for (int k = 0; k < 4; k++) ring[wr_ptr][k] = data[16*k +: 16];
         wr_ptr = (wr_ptr + 1) % RING;
         if (fill < RING) fill++;
         else old_ptr = (old_ptr + 1) % RING;

         s = '{0, 0, 0, 0};
         for (int i = 0; i < fill; i++) begin
            idx = (old_ptr + i) % RING;
            for (int k = 0; k < 4; k++)
               s[k] += (dot(idx, old_ptr) < 0) ? -longint'(ring[idx][k])
                                               : longint'(ring[idx][k]);
         end
         r.valid[0] = 1'b1;
         unit_scale(s, old_ptr, 0, r);

         if (fill >= WWIN) begin
            base = (wr_ptr + RING - WWIN) % RING;
            newest = (wr_ptr + RING - 1) % RING;
            s = '{0, 0, 0, 0};
            for (int i = 0; i < WWIN; i++) begin
               idx = (base + i) % RING;
               for (int k = 0; k < 4; k++) begin
                  c = (dot(idx, newest) < 0) ? -longint'(ring[idx][k])
                                             : longint'(ring[idx][k]);
                  s[k] += c * longint'(weight(4'(i)));
               end
            end
            r.valid[1] = 1'b1;
            unit_scale(s, newest, 4, r);
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic [127:0] data, logic [1:0] user);
         avg_result_type e;
         string fname [8] = '{"mean_w", "mean_x", "mean_y", "mean_z",
                              "wmean_w", "wmean_x", "wmean_y", "wmean_z"};
         if (pending.size() == 0) begin
            $display("%0t: unexpected result tdata=%h tuser=%b", $time, data, user);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (user[0] !== e.valid[0]) begin
            $display("%0t: mean_valid expected %b actual %b", $time, e.valid[0], user[0]);
            errors++;
         end
         if (user[1] !== e.valid[1]) begin
            $display("%0t: wmean_valid expected %b actual %b", $time, e.valid[1], user[1]);
            errors++;
         end
         for (int k = 0; k < 8; k++)
            if (data[16*k +: 16] !== e.comp[k]) begin
               $display("%0t: %s expected %h actual %h", $time, fname[k], e.comp[k],
                        data[16*k +: 16]);
               errors++;
            end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   qwa_scoreboard sb = new();
   int  snd_idle = 24;
   int  rcv_idle = 46;
   bit  long_hold = 0;
   int  hold_cnt = 0;

   quaternion_window_averager dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_request(req_tuser[0], req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // receiver; a long hold-off lets requests back up behind a held result
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold) begin
         long_hold = 0;
         hold_cnt = 3000;
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   task automatic send(logic cmd, logic [15:0] w, logic [15:0] x,
                       logic [15:0] y, logic [15:0] z);
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {z, y, x, w};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic push(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
      send(CMD_PUSH, w, x, y, z);
   endtask

   function automatic logic [15:0] pick_comp(int mode);
      case (mode)
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(64)) - 16'd32;
         default: return ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
      endcase
   endfunction

   initial begin
      int mode;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(CMD_CLEAR, 16'h1234, 16'h0, 16'hffff, 16'h8000);
      push(16'h0000, 16'h0000, 16'h0000, 16'h0000);   // zero sum: oldest returned
      send(CMD_CLEAR, 0, 0, 0, 0);
      push(16'h8000, 16'h8000, 16'h8000, 16'h8000);   // negation of full negative
      push(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);   // flipped against oldest
      push(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
      push(16'h0000, 16'h8000, 16'h0000, 16'h0000);
      push(16'h0000, 16'h0000, 16'h7fff, 16'h0000);
      push(16'h0000, 16'h0000, 16'h0000, 16'h8000);
      push(16'h5a82, 16'ha57e, 16'h0000, 16'h0000);
      push(16'h0001, 16'hffff, 16'h0001, 16'hffff);
      push(16'h4000, 16'h4000, 16'hc000, 16'h4000);
      push(16'h8000, 16'h0000, 16'h0000, 16'h0000);   // tenth sample
      push(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
      send(CMD_CLEAR, 0, 0, 0, 0);
      repeat (10) push(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // weighted zero sum
      push(16'h7fff, 16'h0000, 16'h0000, 16'h0000);   // single-sample saturation
      send(CMD_CLEAR, 0, 0, 0, 0);

      for (int n = 0; n < 850; n++) begin
         if (n == 283) begin snd_idle = 46; rcv_idle = 24; end
         if (n == 566) begin snd_idle = 0;  rcv_idle = 0;  end
         if (n == 100) long_hold = 1;
         mode = $urandom_range(99);
         if (mode < 3)
            send(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         else if (mode < 7)
            push(16'h0000, 16'h0000, 16'h0000, 16'h0000);
         else if (mode < 12)
            push(pick_comp(2), pick_comp(2), pick_comp(2), pick_comp(2));
         else if (mode < 25)
            push(pick_comp(1), pick_comp(1), pick_comp(1), pick_comp(1));
         else
            push(pick_comp(0), pick_comp(0), pick_comp(0), pick_comp(0));
      end
      req_tvalid <= 1'b0;

      // wait for a clock edge so the last accepted request is already noted
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #60ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
